// ===== rtl/pmrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrd_pkg
// Shared types and constants for the packet memory receive deframer.
// ----------------------------------------------------------------------------
package pmrd_pkg;

   localparam int COUNT_BITS     = 11;
   localparam int FLEN_BITS      = 11;
   localparam int CMP_BITS       = (COUNT_BITS > FLEN_BITS) ? COUNT_BITS : FLEN_BITS;
   localparam int RSP_TDATA_BITS = ((8 + FLEN_BITS + 7) / 8) * 8;

   localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(6);
   localparam logic [COUNT_BITS-1:0] ODD_ADJ   = COUNT_BITS'(5);
   localparam logic [COUNT_BITS-1:0] EVEN_ADJ  = COUNT_BITS'(6);

   localparam logic [15:0] ST_ALIGN    = 16'h8000;
   localparam logic [15:0] ST_CRC      = 16'h2000;
   localparam logic [15:0] ST_ODD      = 16'h1000;
   localparam logic [15:0] ST_LONG     = 16'h0800;
   localparam logic [15:0] ST_SHORT    = 16'h0400;
   localparam logic [15:0] ST_ERR_MASK = ST_ALIGN | ST_CRC | ST_LONG | ST_SHORT;

   localparam logic [FLEN_BITS-1:0] MAX_LEN_RESET = FLEN_BITS'(16'h07FF);

   // Depth must be a power of two; the pointers wrap naturally.
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_STATUS_HI,
      PH_COUNT_LO,
      PH_COUNT_HI,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_EMPTY,
      KIND_IOERR,
      KIND_BIG
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           data_byte;
      logic                 last;
      logic [FLEN_BITS-1:0] frame_length;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ===== rtl/pmrd_front.sv =====
// ----------------------------------------------------------------------------
// pmrd_front
// Header parser: takes one byte per transaction, judges the frame on the last
// count byte and pushes each result into the queue.
// ----------------------------------------------------------------------------
module pmrd_front import pmrd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   input  logic                 csr_wr_en,
   input  logic [FLEN_BITS-1:0] csr_wr_data,
   input  fifo_status_type      fifo_status,
   output logic                 push,
   output result_type           push_item
);

   phase_type             phase_ff, phase_in;
   logic [7:0]            status_hi_ff, status_hi_in;
   logic [7:0]            cnt_lo_ff, cnt_lo_in;
   logic [COUNT_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [FLEN_BITS-1:0]  frame_len_ff, frame_len_in;
   logic [FLEN_BITS-1:0]  max_len_ff, max_len_in;

   logic                  accept;
   logic [15:0]           count_full;
   logic [COUNT_BITS-1:0] count;
   logic [15:0]           status_word;
   logic                  io_err;
   logic [COUNT_BITS-1:0] len;
   logic [CMP_BITS-1:0]   len_cmp;
   logic                  too_big;
   logic                  len_zero;
   logic                  last_data;

   assign req_tready = !fifo_status.full;
   assign accept     = req_tvalid && req_tready;

   assign count_full  = {req_tdata, cnt_lo_ff};
   assign count       = count_full[COUNT_BITS-1:0];
   assign status_word = {status_hi_ff, 8'h00};
   assign io_err      = (count < MIN_COUNT) || ((status_word & ST_ERR_MASK) != 16'h0000);
   assign len         = count - (((status_word & ST_ODD) != 16'h0000) ? ODD_ADJ : EVEN_ADJ);
   assign len_cmp     = CMP_BITS'(len);
   assign too_big     = len_cmp > CMP_BITS'(max_len_ff);
   assign len_zero    = (len == '0);
   assign last_data   = (bytes_left_ff == COUNT_BITS'(1));

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_tuser) begin
            phase_in = PH_STATUS_HI;
         end else begin
            unique case (phase_ff)
               PH_IDLE:      phase_in = PH_IDLE;
               PH_STATUS_HI: phase_in = PH_COUNT_LO;
               PH_COUNT_LO:  phase_in = PH_COUNT_HI;
               PH_COUNT_HI:  phase_in = (io_err || too_big || len_zero) ? PH_IDLE : PH_DATA;
               PH_DATA:      phase_in = last_data ? PH_IDLE : PH_DATA;
               default:      phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      push                   = 1'b0;
      push_item.kind         = KIND_DATA;
      push_item.data_byte    = 8'h00;
      push_item.last         = 1'b1;
      push_item.frame_length = '0;
      if (accept && !req_tuser) begin
         unique case (phase_ff)
            PH_COUNT_HI: begin
               push = 1'b1;
               priority if (io_err) begin
                  push_item.kind = KIND_IOERR;
               end else if (too_big) begin
                  push_item.kind         = KIND_BIG;
                  push_item.frame_length = len_cmp[FLEN_BITS-1:0];
               end else if (len_zero) begin
                  push_item.kind = KIND_EMPTY;
               end else begin
                  push = 1'b0;
               end
            end
            PH_DATA: begin
               push                   = 1'b1;
               push_item.data_byte    = req_tdata;
               push_item.last         = last_data;
               push_item.frame_length = frame_len_ff;
            end
            default: push = 1'b0;
         endcase
      end
   end

   always_comb begin
      status_hi_in  = status_hi_ff;
      cnt_lo_in     = cnt_lo_ff;
      bytes_left_in = bytes_left_ff;
      frame_len_in  = frame_len_ff;
      max_len_in    = csr_wr_en ? csr_wr_data : max_len_ff;
      if (accept && !req_tuser) begin
         unique case (phase_ff)
            PH_STATUS_HI: status_hi_in = req_tdata;
            PH_COUNT_LO:  cnt_lo_in    = req_tdata;
            PH_COUNT_HI: begin
               bytes_left_in = len;
               frame_len_in  = len_cmp[FLEN_BITS-1:0];
            end
            PH_DATA:      bytes_left_in = bytes_left_ff - COUNT_BITS'(1);
            default:      bytes_left_in = bytes_left_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         phase_ff   <= phase_in;
         max_len_ff <= max_len_in;
      end
      status_hi_ff  <= status_hi_in;
      cnt_lo_ff     <= cnt_lo_in;
      bytes_left_ff <= bytes_left_in;
      frame_len_ff  <= frame_len_in;
   end

   a_data_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("data phase with no bytes left");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("result pushed into a full queue");

endmodule

// ===== rtl/pmrd_fifo.sv =====
// ----------------------------------------------------------------------------
// pmrd_fifo
// Short result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module pmrd_fifo import pmrd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_type      push_item,
   input  logic            pop,
   output result_type      pop_item,
   output fifo_status_type status
);

   result_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (!reset && push && !pop) |=> count_ff == $past(count_ff) + FIFO_CNT_BITS'(1))
      else $error("queue count did not follow a push");

endmodule

// ===== rtl/pmrd_back.sv =====
// ----------------------------------------------------------------------------
// pmrd_back
// Output stage: drains the queue into a registered result that is held until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module pmrd_back import pmrd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type fifo_status,
   input  result_type      pop_item,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output result_type      rsp_item
);

   logic       valid_ff, valid_in;
   result_type item_ff, item_in;

   assign pop        = !fifo_status.empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (pop) begin
         valid_in = 1'b1;
         item_in  = pop_item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   a_verdict_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && item_ff.kind != KIND_DATA) |-> (item_ff.last && item_ff.data_byte == 8'h00))
      else $error("verdict result without last flag or with data");

endmodule

// ===== rtl/packet_memory_rx_deframer_top.sv =====
// ----------------------------------------------------------------------------
// packet_memory_rx_deframer_top
// Receive deframer for bytes read from controller packet memory.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and gives at most one result per byte.
// A result reaches the output from the byte that causes it through a
// four-entry queue and then an output register. The input stays ready
// at one byte per cycle until the queue fills, which happens only when the
// output side holds off.
module packet_memory_rx_deframer_top import pmrd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // mem_byte
   input  logic                      req_tuser,   // frame_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // data_byte, frame_length, zero pad
   output logic [1:0]                rsp_tuser,   // kind
   output logic                      rsp_tlast,   // last
   input  logic                      csr_wr_en,
   input  logic [FLEN_BITS-1:0]      csr_wr_data  // max_frame_len
);

   fifo_status_type fifo_status;
   logic            push;
   logic            pop;
   result_type      push_item;
   result_type      pop_item;
   result_type      rsp_item;

   pmrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_item   (push_item)
   );

   pmrd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (fifo_status)
   );

   pmrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_item    (rsp_item)
   );

   assign rsp_tdata = RSP_TDATA_BITS'({rsp_item.frame_length, rsp_item.data_byte});
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule
